// ----- rtl/dns_response_parser_top_defines.svh -----
// ----------------------------------------------------------------------------
// DNS response parser assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DNS_RESPONSE_PARSER_TOP_DEFINES_SVH
`define DNS_RESPONSE_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/drp_pkg.sv -----
// ----------------------------------------------------------------------------
// DNS response parser package
// Parse phases, result codes and the data form decode shared by the parser.
// ----------------------------------------------------------------------------
package drp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_QNAME  = 3'd1,
    PH_QFIXED = 3'd2,
    PH_ANAME  = 3'd3,
    PH_APTR   = 3'd4,
    PH_RRHDR  = 3'd5,
    PH_RDATA  = 3'd6,
    PH_IDLE   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    NM_FIRST   = 2'd0,
    NM_LATER   = 2'd1,
    NM_STOPPED = 2'd2
  } name_mode_t;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] FORM_RAW  = 2'd0;
  localparam logic [1:0] FORM_ADDR = 2'd1;
  localparam logic [1:0] FORM_NAME = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_NOT_RESP = 3'd2;
  localparam logic [2:0] ST_RCODE    = 3'd3;
  localparam logic [2:0] ST_OVERSIZE = 3'd4;

  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_PTR   = 16'd12;
  localparam logic [15:0] TYPE_AAAA  = 16'd28;

  localparam logic [7:0] CHAR_DOT = 8'h2E;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [15:0] record_number;
    logic [15:0] record_type;
    logic [31:0] record_ttl;
    logic [15:0] rdata_length;
    logic [1:0]  data_form;
    logic [7:0]  data_byte;
    logic [2:0]  packet_status;
    logic [15:0] complete_records;
  } result_t;

  // How the rdata of a record is presented.
  function automatic logic [1:0] form_of(input logic [15:0] rtype, input logic [15:0] rlen);
    logic [1:0] f;
    f = FORM_RAW;
    if (rtype == TYPE_A && rlen == 16'd4) f = FORM_ADDR;
    else if (rtype == TYPE_AAAA && rlen == 16'd16) f = FORM_ADDR;
    else if (rtype == TYPE_CNAME || rtype == TYPE_PTR) f = FORM_NAME;
    return f;
  endfunction

endpackage

// ----- rtl/dns_response_parser_top.sv -----
// ----------------------------------------------------------------------------
// DNS response parser
// Latency: the first result of a byte is offered in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and out_tready
// stays high; a byte giving more results (up to three) holds the input while the result
// register drains. Reset is synchronous, active low, and returns to the header phase.
// ----------------------------------------------------------------------------
`include "dns_response_parser_top_defines.svh"

module dns_response_parser_top #(
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // packet_byte [7:0]
  input  logic         in_tlast,   // end_of_packet
  output logic         out_tvalid,
  input  logic         out_tready,
  // record_number [15:0], record_type [31:16], record_ttl [63:32],
  // rdata_length [79:64], data_form [81:80], data_byte [89:82],
  // packet_status [92:90], complete_records [108:93], zero fill above
  output logic [111:0] out_tdata,
  output logic [1:0]   out_tuser   // item_kind [1:0]
);

  // Byte count at which a packet is judged oversize.
  localparam logic [15:0] MaxBytes = 16'(MAX_PACKET_BYTES);

  // Events raised by one accepted byte, with the record context they carry.
  typedef struct packed {
    logic        data_en;
    logic [7:0]  data_val;
    logic        done_en;
    logic [15:0] rec_num;
    logic [15:0] rec_type;
    logic [31:0] rec_ttl;
    logic [15:0] rec_len;
    logic        status_en;
    logic [2:0]  status_code;
    logic [15:0] status_recs;
  } event_t;

  // Parser state.
  drp_pkg::phase_t     phase_r, phase_nxt, phase_sel;
  logic [15:0]         pos_r, pos_nxt;
  logic [15:0]         flags_r, flags_nxt;
  logic [15:0]         qleft_r, qleft_nxt;
  logic [15:0]         aleft_r, aleft_nxt;
  logic [7:0]          lbl_r, lbl_nxt;
  logic [3:0]          fbs_r, fbs_nxt;
  logic [15:0]         type_r, type_nxt;
  logic [31:0]         ttl_r, ttl_nxt;
  logic [15:0]         rdlen_r, rdlen_nxt;
  logic [15:0]         rdleft_r, rdleft_nxt;
  drp_pkg::name_mode_t nmode_r, nmode_nxt;
  logic [15:0]         recs_r, recs_nxt;
  logic [2:0]          fail_r, fail_nxt;
  logic                finish;
  logic                next_sec;
  event_t              ev;

  // Result register: up to three pending results, the head at slot 0.
  drp_pkg::result_t    slot_r [3];
  drp_pkg::result_t    slot_nxt [3];
  logic [1:0]          cnt_r, cnt_nxt;
  logic [1:0]          fill;
  logic                in_acc;
  logic                out_pop;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_pop    = out_tvalid && out_tready;
  // A new byte may load the result register once it is empty or emptying.
  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_pop);
  assign in_acc     = in_tvalid && in_tready;

  assign out_tuser = slot_r[0].item_kind;
  assign out_tdata = {3'b000, slot_r[0].complete_records, slot_r[0].packet_status,
                      slot_r[0].data_byte, slot_r[0].data_form, slot_r[0].rdata_length,
                      slot_r[0].record_ttl, slot_r[0].record_type, slot_r[0].record_number};

  // Next state: one step of the parse for the byte on the input.
  always_comb begin
    phase_sel  = phase_r;
    pos_nxt    = pos_r;
    flags_nxt  = flags_r;
    qleft_nxt  = qleft_r;
    aleft_nxt  = aleft_r;
    lbl_nxt    = lbl_r;
    fbs_nxt    = fbs_r;
    type_nxt   = type_r;
    ttl_nxt    = ttl_r;
    rdlen_nxt  = rdlen_r;
    rdleft_nxt = rdleft_r;
    nmode_nxt  = nmode_r;
    recs_nxt   = recs_r;
    fail_nxt   = fail_r;
    finish     = 1'b0;
    next_sec   = 1'b0;
    ev         = '0;

    // Any byte past the size limit stops parsing, unless a header failure came first.
    if (pos_r >= MaxBytes && fail_r == drp_pkg::ST_OK) begin
      fail_nxt  = drp_pkg::ST_OVERSIZE;
      phase_sel = drp_pkg::PH_IDLE;
    end
    if (pos_r != 16'hFFFF) pos_nxt = pos_r + 16'd1;
    phase_nxt = phase_sel;

    unique case (phase_sel)
      drp_pkg::PH_HEADER: begin
        if (pos_r == 16'd2 || pos_r == 16'd3) flags_nxt = {flags_r[7:0], in_tdata};
        else if (pos_r == 16'd4 || pos_r == 16'd5) qleft_nxt = {qleft_r[7:0], in_tdata};
        else if (pos_r == 16'd6 || pos_r == 16'd7) aleft_nxt = {aleft_r[7:0], in_tdata};
        if (pos_r >= 16'd11) begin
          if (!flags_r[15]) begin
            fail_nxt  = drp_pkg::ST_NOT_RESP;
            phase_nxt = drp_pkg::PH_IDLE;
          end else if (flags_r[3:0] != 4'd0) begin
            fail_nxt  = drp_pkg::ST_RCODE;
            phase_nxt = drp_pkg::PH_IDLE;
          end else begin
            next_sec = 1'b1;
          end
        end
      end
      drp_pkg::PH_QNAME: begin
        // Question names are plain labels: no pointer check, so a nonzero byte at a label start is a length.
        if (lbl_r != 8'd0) lbl_nxt = lbl_r - 8'd1;
        else if (in_tdata == 8'd0) begin
          phase_nxt = drp_pkg::PH_QFIXED;
          fbs_nxt   = 4'd0;
        end else lbl_nxt = in_tdata;
      end
      drp_pkg::PH_QFIXED: begin
        fbs_nxt = fbs_r + 4'd1;
        if (fbs_nxt >= 4'd4) begin
          qleft_nxt = qleft_r - 16'd1;
          next_sec  = 1'b1;
        end
      end
      drp_pkg::PH_ANAME: begin
        if (lbl_r != 8'd0) lbl_nxt = lbl_r - 8'd1;
        else if (in_tdata[7:6] == 2'b11) phase_nxt = drp_pkg::PH_APTR;
        else if (in_tdata == 8'd0) begin
          phase_nxt = drp_pkg::PH_RRHDR;
          fbs_nxt   = 4'd0;
        end else lbl_nxt = in_tdata;
      end
      drp_pkg::PH_APTR: begin
        // Second pointer byte ends the name; no terminator follows.
        phase_nxt = drp_pkg::PH_RRHDR;
        fbs_nxt   = 4'd0;
      end
      drp_pkg::PH_RRHDR: begin
        if (fbs_r == 4'd0) type_nxt = {8'd0, in_tdata};
        else if (fbs_r == 4'd1) type_nxt = {type_r[7:0], in_tdata};
        else if (fbs_r >= 4'd4 && fbs_r <= 4'd7) ttl_nxt = {ttl_r[23:0], in_tdata};
        else if (fbs_r == 4'd8) rdlen_nxt = {8'd0, in_tdata};
        else if (fbs_r == 4'd9) rdlen_nxt = {rdlen_r[7:0], in_tdata};
        fbs_nxt = fbs_r + 4'd1;
        if (fbs_nxt >= 4'd10) begin
          fbs_nxt    = 4'd0;
          rdleft_nxt = rdlen_nxt;
          nmode_nxt  = drp_pkg::NM_FIRST;
          lbl_nxt    = 8'd0;
          if (rdlen_nxt == 16'd0) finish = 1'b1;
          else phase_nxt = drp_pkg::PH_RDATA;
        end
      end
      drp_pkg::PH_RDATA: begin
        if (drp_pkg::form_of(type_r, rdlen_r) != drp_pkg::FORM_NAME) begin
          ev.data_en  = 1'b1;
          ev.data_val = in_tdata;
        end else if (nmode_r != drp_pkg::NM_STOPPED) begin
          if (lbl_r != 8'd0) begin
            ev.data_en  = 1'b1;
            ev.data_val = in_tdata;
            lbl_nxt     = lbl_r - 8'd1;
          end else if (in_tdata[7:6] != 2'b00 || in_tdata == 8'd0) begin
            // A byte with either top bit set (a pointer) or the root label ends the name; the rest is skipped.
            nmode_nxt = drp_pkg::NM_STOPPED;
          end else begin
            if (nmode_r == drp_pkg::NM_LATER) begin
              ev.data_en  = 1'b1;
              ev.data_val = drp_pkg::CHAR_DOT;
            end
            nmode_nxt = drp_pkg::NM_LATER;
            lbl_nxt   = in_tdata;
          end
        end
        rdleft_nxt = rdleft_r - 16'd1;
        if (rdleft_nxt == 16'd0) finish = 1'b1;
      end
      drp_pkg::PH_IDLE: begin
      end
    endcase

    if (finish) begin
      ev.done_en = 1'b1;
      recs_nxt   = recs_r + 16'd1;
      aleft_nxt  = aleft_r - 16'd1;
      next_sec   = 1'b1;
    end
    if (next_sec) begin
      if (qleft_nxt != 16'd0) phase_nxt = drp_pkg::PH_QNAME;
      else if (aleft_nxt != 16'd0) phase_nxt = drp_pkg::PH_ANAME;
      else phase_nxt = drp_pkg::PH_IDLE;
      lbl_nxt = 8'd0;
      fbs_nxt = 4'd0;
    end

    ev.rec_num  = recs_r;
    ev.rec_type = type_nxt;
    ev.rec_ttl  = ttl_nxt;
    ev.rec_len  = rdlen_nxt;

    // The final byte reports the packet status and clears the parse state.
    if (in_tlast) begin
      ev.status_en   = 1'b1;
      ev.status_code = (pos_nxt < 16'd12) ? drp_pkg::ST_SHORT : fail_nxt;
      ev.status_recs = recs_nxt;
      phase_nxt  = drp_pkg::PH_HEADER;
      pos_nxt    = 16'd0;
      flags_nxt  = 16'd0;
      qleft_nxt  = 16'd0;
      aleft_nxt  = 16'd0;
      lbl_nxt    = 8'd0;
      fbs_nxt    = 4'd0;
      type_nxt   = 16'd0;
      ttl_nxt    = 32'd0;
      rdlen_nxt  = 16'd0;
      rdleft_nxt = 16'd0;
      nmode_nxt  = drp_pkg::NM_FIRST;
      recs_nxt   = 16'd0;
      fail_nxt   = drp_pkg::ST_OK;
    end
  end

  // Outputs: pack the raised events, in order, into the result slots.
  always_comb begin
    for (int i = 0; i < 3; i++) slot_nxt[i] = '0;
    fill = 2'd0;
    if (ev.data_en) begin
      slot_nxt[fill].item_kind     = drp_pkg::KIND_DATA;
      slot_nxt[fill].record_number = ev.rec_num;
      slot_nxt[fill].record_type   = ev.rec_type;
      slot_nxt[fill].record_ttl    = ev.rec_ttl;
      slot_nxt[fill].rdata_length  = ev.rec_len;
      slot_nxt[fill].data_form     = drp_pkg::form_of(ev.rec_type, ev.rec_len);
      slot_nxt[fill].data_byte     = ev.data_val;
      fill = fill + 2'd1;
    end
    if (ev.done_en) begin
      slot_nxt[fill].item_kind     = drp_pkg::KIND_DONE;
      slot_nxt[fill].record_number = ev.rec_num;
      slot_nxt[fill].record_type   = ev.rec_type;
      slot_nxt[fill].record_ttl    = ev.rec_ttl;
      slot_nxt[fill].rdata_length  = ev.rec_len;
      slot_nxt[fill].data_form     = drp_pkg::form_of(ev.rec_type, ev.rec_len);
      fill = fill + 2'd1;
    end
    if (ev.status_en) begin
      slot_nxt[fill].item_kind        = drp_pkg::KIND_STATUS;
      slot_nxt[fill].record_number    = ev.status_recs;
      slot_nxt[fill].packet_status    = ev.status_code;
      slot_nxt[fill].complete_records = ev.status_recs;
      fill = fill + 2'd1;
    end
    cnt_nxt = fill;
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= drp_pkg::PH_HEADER;
      pos_r    <= 16'd0;
      flags_r  <= 16'd0;
      qleft_r  <= 16'd0;
      aleft_r  <= 16'd0;
      lbl_r    <= 8'd0;
      fbs_r    <= 4'd0;
      type_r   <= 16'd0;
      ttl_r    <= 32'd0;
      rdlen_r  <= 16'd0;
      rdleft_r <= 16'd0;
      nmode_r  <= drp_pkg::NM_FIRST;
      recs_r   <= 16'd0;
      fail_r   <= drp_pkg::ST_OK;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      flags_r  <= flags_nxt;
      qleft_r  <= qleft_nxt;
      aleft_r  <= aleft_nxt;
      lbl_r    <= lbl_nxt;
      fbs_r    <= fbs_nxt;
      type_r   <= type_nxt;
      ttl_r    <= ttl_nxt;
      rdlen_r  <= rdlen_nxt;
      rdleft_r <= rdleft_nxt;
      nmode_r  <= nmode_nxt;
      recs_r   <= recs_nxt;
      fail_r   <= fail_nxt;
    end
  end

  // Result register: loads on an accepted byte, otherwise shifts on each taken request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_acc) begin
      cnt_r <= cnt_nxt;
    end else if (out_pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) slot_r[i] <= slot_nxt[i];
    end else if (out_pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  `DRP_ASSERT_NEXT(a_eop_resets, in_acc && in_tlast, phase_r == drp_pkg::PH_HEADER && pos_r == 16'd0, "parser not back in header phase after end of packet")
  `DRP_ASSERT_SAME(a_status_last, out_tvalid && out_tuser == drp_pkg::KIND_STATUS, cnt_r == 2'd1, "status result is not the last pending result")
  `DRP_ASSERT_SAME(a_rdata_nonempty, phase_r == drp_pkg::PH_RDATA, rdleft_r != 16'd0, "rdata phase with no bytes left")
  `DRP_ASSERT_SAME(a_fail_idle, fail_r != drp_pkg::ST_OK, phase_r == drp_pkg::PH_IDLE, "failure recorded while still parsing")

endmodule
